@@ design/gsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared widths, register indexes and reset values of the gear shift
// controller.
// ----------------------------------------------------------------------------
package gsc_pkg;

    localparam int unsigned GEARS        = 5;
    localparam int unsigned SPEED_W      = 10;
    localparam int unsigned RPM_W        = 16;
    localparam int unsigned GEAR_W       = 3;
    localparam int unsigned CNT_W        = 16;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned FRAC_BITS    = 8;
    localparam int unsigned PROD_W       = SPEED_W + CFG_DATA_W;

    typedef logic [SPEED_W-1:0]    speed_t;
    typedef logic [RPM_W-1:0]      rpm_t;
    typedef logic [GEAR_W-1:0]     gear_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FACTOR_GEAR1      = 3'd0,
        REG_FACTOR_GEAR2      = 3'd1,
        REG_FACTOR_GEAR3      = 3'd2,
        REG_FACTOR_GEAR4      = 3'd3,
        REG_FACTOR_GEAR5      = 3'd4,
        REG_UPSHIFT_RPM       = 3'd5,
        REG_DOWNSHIFT_RPM     = 3'd6,
        REG_TOP_DOWNSHIFT_RPM = 3'd7
    } cfg_idx_t;

    localparam gear_t GEAR_FIRST = 3'd0;
    localparam gear_t GEAR_TOP   = 3'(GEARS - 1);

    localparam cfg_data_t FACTOR_GEAR1_RST      = 16'd26855;
    localparam cfg_data_t FACTOR_GEAR2_RST      = 16'd18717;
    localparam cfg_data_t FACTOR_GEAR3_RST      = 16'd12930;
    localparam cfg_data_t FACTOR_GEAR4_RST      = 16'd9042;
    localparam cfg_data_t FACTOR_GEAR5_RST      = 16'd7595;
    localparam cfg_data_t UPSHIFT_RPM_RST       = 16'd2500;
    localparam cfg_data_t DOWNSHIFT_RPM_RST     = 16'd700;
    localparam cfg_data_t TOP_DOWNSHIFT_RPM_RST = 16'd2000;

    localparam rpm_t   RPM_SAT       = '1;
    localparam rpm_t   RPM_MIN_RST   = '1;
    localparam speed_t SPEED_MIN_RST = '1;

endpackage

@@ design/gsc_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsc_if
// Valid/ready channels of the gear shift controller: speed samples,
// results and configuration writes.
// ----------------------------------------------------------------------------
interface gsc_sample_if;
    import gsc_pkg::*;

    logic   valid;
    logic   ready;
    speed_t speed_kmh;

    modport source (output valid, output speed_kmh, input ready);
    modport sink   (input valid, input speed_kmh, output ready);
endinterface

interface gsc_result_if;
    import gsc_pkg::*;

    logic   valid;
    logic   ready;
    rpm_t   engine_rpm;
    gear_t  gear_used;
    gear_t  next_gear;
    logic   shifted_up;
    logic   shifted_down;
    rpm_t   min_rpm_seen;
    rpm_t   max_rpm_seen;
    speed_t min_speed_seen;
    speed_t max_speed_seen;
    cnt_t   upshift_total;
    cnt_t   downshift_total;

    modport source (
        output valid, output engine_rpm, output gear_used, output next_gear,
        output shifted_up, output shifted_down, output min_rpm_seen,
        output max_rpm_seen, output min_speed_seen, output max_speed_seen,
        output upshift_total, output downshift_total, input ready
    );
    modport sink (
        input valid, input engine_rpm, input gear_used, input next_gear,
        input shifted_up, input shifted_down, input min_rpm_seen,
        input max_rpm_seen, input min_speed_seen, input max_speed_seen,
        input upshift_total, input downshift_total, output ready
    );
endinterface

interface gsc_cfg_if;
    import gsc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    cfg_data_t            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/gear_shift_controller_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_shift_controller_unit
// Five-gear shift controller: rpm from speed, per-gear min/max and shift
// statistics, shift decision per speed sample.
// ----------------------------------------------------------------------------
// Takes one speed sample per cycle while the result is not stalled and
// returns one result per sample: the sample lands in an input register, and
// the 10x16 rpm multiply, the store updates and the shift decision then run
// into the result register. A stalled result blocks new samples once the
// input register holds one. Consecutive samples see the gear left by the
// previous one. Configuration writes are always ready and take effect at
// once; unused indexes do not exist since all eight codes are registers.
// ----------------------------------------------------------------------------
module gear_shift_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    gsc_sample_if.sink  sample,
    gsc_result_if.source result,
    gsc_cfg_if.sink     cfg
);
    import gsc_pkg::*;

    // configuration
    cfg_data_t factor_reg [GEARS];
    rpm_t      upshift_rpm_reg;
    rpm_t      downshift_rpm_reg;
    rpm_t      top_downshift_rpm_reg;

    // state
    gear_t  current_gear_reg;
    rpm_t   rpm_max_reg   [GEARS];
    rpm_t   rpm_min_reg   [GEARS];
    speed_t speed_max_reg [GEARS];
    speed_t speed_min_reg [GEARS];
    cnt_t   up_cnt_reg    [GEARS];
    cnt_t   down_cnt_reg  [GEARS];

    // input stage
    logic   in_valid_reg;
    speed_t speed_reg;

    // result stage
    logic   out_valid_reg;
    rpm_t   rpm_out_reg;
    gear_t  gear_used_reg;
    gear_t  next_gear_reg;
    logic   up_reg;
    logic   down_reg;
    rpm_t   rpm_min_out_reg;
    rpm_t   rpm_max_out_reg;
    speed_t speed_min_out_reg;
    speed_t speed_max_out_reg;
    cnt_t   up_cnt_out_reg;
    cnt_t   down_cnt_out_reg;

    logic                      advance;
    logic                      process;
    logic [2:0]                g;
    logic [PROD_W-1:0]         product;
    logic [PROD_W-FRAC_BITS-1:0] rpm_wide;
    rpm_t                      rpm;
    rpm_t                      rpm_min_next;
    rpm_t                      rpm_max_next;
    speed_t                    speed_min_next;
    speed_t                    speed_max_next;
    cnt_t                      up_cnt_next;
    cnt_t                      down_cnt_next;
    gear_t                     gear_next;
    logic                      up;
    logic                      down;

    assign advance      = !out_valid_reg || result.ready;
    assign process      = in_valid_reg && advance;
    assign sample.ready = !in_valid_reg || advance;
    assign cfg.ready    = 1'b1;

    // ---- datapath ----
    always_comb
    begin
        g = (current_gear_reg > GEAR_TOP) ? GEAR_TOP : current_gear_reg;
        product  = PROD_W'(speed_reg) * PROD_W'(factor_reg[g]);
        rpm_wide = product[PROD_W-1:FRAC_BITS];
        rpm      = (|rpm_wide[PROD_W-FRAC_BITS-1:RPM_W]) ? RPM_SAT
                                                          : rpm_wide[RPM_W-1:0];

        rpm_max_next   = (rpm > rpm_max_reg[g]) ? rpm : rpm_max_reg[g];
        rpm_min_next   = (rpm < rpm_min_reg[g]) ? rpm : rpm_min_reg[g];
        speed_max_next = (speed_reg > speed_max_reg[g]) ? speed_reg : speed_max_reg[g];
        speed_min_next = (speed_reg < speed_min_reg[g]) ? speed_reg : speed_min_reg[g];

        up        = 1'b0;
        down      = 1'b0;
        gear_next = g;
        if (g != GEAR_TOP)
        begin
            if (rpm >= upshift_rpm_reg)
            begin
                up        = 1'b1;
                gear_next = g + 3'd1;
            end
            else if (g != GEAR_FIRST && rpm <= downshift_rpm_reg)
            begin
                down      = 1'b1;
                gear_next = g - 3'd1;
            end
        end
        else if (rpm <= top_downshift_rpm_reg)
        begin
            down      = 1'b1;
            gear_next = g - 3'd1;
        end

        up_cnt_next   = up_cnt_reg[g] + CNT_W'(up);
        down_cnt_next = down_cnt_reg[g] + CNT_W'(down);
    end

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg[0]         <= FACTOR_GEAR1_RST;
            factor_reg[1]         <= FACTOR_GEAR2_RST;
            factor_reg[2]         <= FACTOR_GEAR3_RST;
            factor_reg[3]         <= FACTOR_GEAR4_RST;
            factor_reg[4]         <= FACTOR_GEAR5_RST;
            upshift_rpm_reg       <= UPSHIFT_RPM_RST;
            downshift_rpm_reg     <= DOWNSHIFT_RPM_RST;
            top_downshift_rpm_reg <= TOP_DOWNSHIFT_RPM_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg_idx_t'(cfg.index))
                REG_FACTOR_GEAR1:      factor_reg[0]         <= cfg.data;
                REG_FACTOR_GEAR2:      factor_reg[1]         <= cfg.data;
                REG_FACTOR_GEAR3:      factor_reg[2]         <= cfg.data;
                REG_FACTOR_GEAR4:      factor_reg[3]         <= cfg.data;
                REG_FACTOR_GEAR5:      factor_reg[4]         <= cfg.data;
                REG_UPSHIFT_RPM:       upshift_rpm_reg       <= cfg.data;
                REG_DOWNSHIFT_RPM:     downshift_rpm_reg     <= cfg.data;
                REG_TOP_DOWNSHIFT_RPM: top_downshift_rpm_reg <= cfg.data;
                default:               ;
            endcase
        end
    end

    // ---- per-gear state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_gear_reg <= GEAR_FIRST;
            for (int i = 0; i < GEARS; i++)
            begin
                rpm_max_reg[i]   <= '0;
                rpm_min_reg[i]   <= RPM_MIN_RST;
                speed_max_reg[i] <= '0;
                speed_min_reg[i] <= SPEED_MIN_RST;
                up_cnt_reg[i]    <= '0;
                down_cnt_reg[i]  <= '0;
            end
        end
        else if (process)
        begin
            current_gear_reg <= gear_next;
            rpm_max_reg[g]   <= rpm_max_next;
            rpm_min_reg[g]   <= rpm_min_next;
            speed_max_reg[g] <= speed_max_next;
            speed_min_reg[g] <= speed_min_next;
            up_cnt_reg[g]    <= up_cnt_next;
            down_cnt_reg[g]  <= down_cnt_next;
        end
    end

    // ---- handshake control ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                in_valid_reg <= sample.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            speed_reg <= sample.speed_kmh;
        end
        if (process)
        begin
            rpm_out_reg       <= rpm;
            gear_used_reg     <= g;
            next_gear_reg     <= gear_next;
            up_reg            <= up;
            down_reg          <= down;
            rpm_min_out_reg   <= rpm_min_next;
            rpm_max_out_reg   <= rpm_max_next;
            speed_min_out_reg <= speed_min_next;
            speed_max_out_reg <= speed_max_next;
            up_cnt_out_reg    <= up_cnt_next;
            down_cnt_out_reg  <= down_cnt_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.engine_rpm      = rpm_out_reg;
    assign result.gear_used       = gear_used_reg;
    assign result.next_gear       = next_gear_reg;
    assign result.shifted_up      = up_reg;
    assign result.shifted_down    = down_reg;
    assign result.min_rpm_seen    = rpm_min_out_reg;
    assign result.max_rpm_seen    = rpm_max_out_reg;
    assign result.min_speed_seen  = speed_min_out_reg;
    assign result.max_speed_seen  = speed_max_out_reg;
    assign result.upshift_total   = up_cnt_out_reg;
    assign result.downshift_total = down_cnt_out_reg;

    // ---- assertions ----
    a_gear_range: assert property (@(posedge clk) disable iff (!rst_n)
        current_gear_reg <= GEAR_TOP)
        else $error("current gear out of range");

    a_one_shift: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(up_reg && down_reg))
        else $error("up and down shift in the same transaction");

    a_up_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && up_reg) |-> (next_gear_reg == gear_used_reg + 3'd1))
        else $error("upshift did not advance one gear");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rpm_min_out_reg <= rpm_max_out_reg
                           && speed_min_out_reg <= speed_max_out_reg))
        else $error("min exceeds max in result");

    a_gear_follows: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> (current_gear_reg == next_gear_reg))
        else $error("gear state does not match last result");

endmodule

@@ dv/gear_shift_controller_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_shift_controller_unit_test
// Self-checking testbench of the gear shift controller.
// ----------------------------------------------------------------------------
// Streams speed samples with random sender gaps and receiver stalls. A local
// predictor tracks gear, per-gear min/max stores and shift counters, and each
// result transaction is checked field by field in order. Covers threshold
// edges, rpm saturation, extreme and random register settings and a shift on
// every sample.
// ----------------------------------------------------------------------------
module gear_shift_controller_unit_test;
    import gsc_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned ITEMS_PER_PHASE = 300;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned MAX_REPORTS     = 10;
    localparam int unsigned DRAIN_CYCLES    = 4;
    localparam int unsigned TOGGLE_ITEMS    = 80;
    localparam cfg_data_t   UNITY_FACTOR    = 16'h0100;
    localparam cfg_data_t   FULL_SCALE      = '1;
    localparam speed_t      SPEED_TOP       = '1;

    typedef struct packed {
        rpm_t   engine_rpm;
        gear_t  gear_used;
        gear_t  next_gear;
        logic   shifted_up;
        logic   shifted_down;
        rpm_t   min_rpm_seen;
        rpm_t   max_rpm_seen;
        speed_t min_speed_seen;
        speed_t max_speed_seen;
        cnt_t   upshift_total;
        cnt_t   downshift_total;
    } shift_outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    gsc_sample_if sample_ch ();
    gsc_result_if result_ch ();
    gsc_cfg_if    cfg_ch ();

    gear_shift_controller_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predictor state
    cfg_data_t gear_factor [GEARS];
    rpm_t      up_thr;
    rpm_t      down_thr;
    rpm_t      top_thr;
    gear_t     cur_gear;
    rpm_t      rpm_hi   [GEARS];
    rpm_t      rpm_lo   [GEARS];
    speed_t    spd_hi   [GEARS];
    speed_t    spd_lo   [GEARS];
    cnt_t      up_cnt   [GEARS];
    cnt_t      down_cnt [GEARS];

    shift_outcome_t outcome_q [$];

    // register values staged for the next programming pass
    cfg_data_t set_factor [GEARS];
    cfg_data_t set_up;
    cfg_data_t set_down;
    cfg_data_t set_top;

    bit          sender_idles;
    bit          receiver_stalls;
    int unsigned burst_left;
    logic [7:0]  stall_pattern = 8'hff;
    int unsigned pattern_age = 0;
    speed_t      walk_speed;
    int unsigned walk_step;

    int unsigned fail_cnt = 0;
    int unsigned samples_in = 0;
    int unsigned results_out = 0;
    int unsigned settings_cnt = 0;
    int unsigned upshifts = 0;
    int unsigned downshifts = 0;
    int unsigned quiet_cycles = 0;

    always #10 clk = ~clk;

    function automatic void reset_model();
        gear_factor[0] = FACTOR_GEAR1_RST;
        gear_factor[1] = FACTOR_GEAR2_RST;
        gear_factor[2] = FACTOR_GEAR3_RST;
        gear_factor[3] = FACTOR_GEAR4_RST;
        gear_factor[4] = FACTOR_GEAR5_RST;
        up_thr   = UPSHIFT_RPM_RST;
        down_thr = DOWNSHIFT_RPM_RST;
        top_thr  = TOP_DOWNSHIFT_RPM_RST;
        cur_gear = GEAR_FIRST;
        for (int g = 0; g < GEARS; g++) begin
            rpm_hi[g]   = '0;
            rpm_lo[g]   = RPM_MIN_RST;
            spd_hi[g]   = '0;
            spd_lo[g]   = SPEED_MIN_RST;
            up_cnt[g]   = '0;
            down_cnt[g] = '0;
        end
    endfunction

    function automatic shift_outcome_t predict_shift(input speed_t spd);
        logic [PROD_W-1:0] scaled;
        gear_t             g;
        gear_t             nxt;
        shift_outcome_t    o;
        g = (cur_gear > GEAR_TOP) ? GEAR_TOP : cur_gear;
        scaled = (spd * gear_factor[g]) >> FRAC_BITS;
        o.engine_rpm = (scaled > RPM_SAT) ? RPM_SAT : scaled[RPM_W-1:0];
        if (o.engine_rpm > rpm_hi[g]) rpm_hi[g] = o.engine_rpm;
        if (o.engine_rpm < rpm_lo[g]) rpm_lo[g] = o.engine_rpm;
        if (spd > spd_hi[g]) spd_hi[g] = spd;
        if (spd < spd_lo[g]) spd_lo[g] = spd;
        nxt = g;
        o.shifted_up   = 1'b0;
        o.shifted_down = 1'b0;
        if (g < GEAR_TOP) begin
            if (o.engine_rpm >= up_thr) begin
                o.shifted_up = 1'b1;
                nxt = g + 3'd1;
            end else if (g > GEAR_FIRST && o.engine_rpm <= down_thr) begin
                o.shifted_down = 1'b1;
                nxt = g - 3'd1;
            end
        end else if (o.engine_rpm <= top_thr) begin
            o.shifted_down = 1'b1;
            nxt = g - 3'd1;
        end
        if (o.shifted_up) begin
            up_cnt[g] = up_cnt[g] + 1'b1;
            upshifts++;
        end
        if (o.shifted_down) begin
            down_cnt[g] = down_cnt[g] + 1'b1;
            downshifts++;
        end
        cur_gear = nxt;
        o.gear_used       = g;
        o.next_gear       = nxt;
        o.min_rpm_seen    = rpm_lo[g];
        o.max_rpm_seen    = rpm_hi[g];
        o.min_speed_seen  = spd_lo[g];
        o.max_speed_seen  = spd_hi[g];
        o.upshift_total   = up_cnt[g];
        o.downshift_total = down_cnt[g];
        return o;
    endfunction

    function automatic void compare_field(input string field, input logic [RPM_W-1:0] exp_v,
                                          input logic [RPM_W-1:0] got_v);
        if (exp_v !== got_v) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $time, field, exp_v, got_v);
        end
    endfunction

    // result check, register tracking and prediction, in that order
    always @(posedge clk) begin
        shift_outcome_t exp_o;
        shift_outcome_t got;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                results_out++;
                got.engine_rpm      = result_ch.engine_rpm;
                got.gear_used       = result_ch.gear_used;
                got.next_gear       = result_ch.next_gear;
                got.shifted_up      = result_ch.shifted_up;
                got.shifted_down    = result_ch.shifted_down;
                got.min_rpm_seen    = result_ch.min_rpm_seen;
                got.max_rpm_seen    = result_ch.max_rpm_seen;
                got.min_speed_seen  = result_ch.min_speed_seen;
                got.max_speed_seen  = result_ch.max_speed_seen;
                got.upshift_total   = result_ch.upshift_total;
                got.downshift_total = result_ch.downshift_total;
                if (outcome_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("[%0t] result transaction with no pending sample", $time);
                end else begin
                    exp_o = outcome_q.pop_front();
                    compare_field("engine_rpm", exp_o.engine_rpm, got.engine_rpm);
                    compare_field("gear_used", RPM_W'(exp_o.gear_used),
                                  RPM_W'(got.gear_used));
                    compare_field("next_gear", RPM_W'(exp_o.next_gear),
                                  RPM_W'(got.next_gear));
                    compare_field("shifted_up", RPM_W'(exp_o.shifted_up),
                                  RPM_W'(got.shifted_up));
                    compare_field("shifted_down", RPM_W'(exp_o.shifted_down),
                                  RPM_W'(got.shifted_down));
                    compare_field("min_rpm_seen", exp_o.min_rpm_seen, got.min_rpm_seen);
                    compare_field("max_rpm_seen", exp_o.max_rpm_seen, got.max_rpm_seen);
                    compare_field("min_speed_seen", RPM_W'(exp_o.min_speed_seen),
                                  RPM_W'(got.min_speed_seen));
                    compare_field("max_speed_seen", RPM_W'(exp_o.max_speed_seen),
                                  RPM_W'(got.max_speed_seen));
                    compare_field("upshift_total", exp_o.upshift_total, got.upshift_total);
                    compare_field("downshift_total", exp_o.downshift_total,
                                  got.downshift_total);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_FACTOR_GEAR1:      gear_factor[0] = cfg_ch.data;
                    REG_FACTOR_GEAR2:      gear_factor[1] = cfg_ch.data;
                    REG_FACTOR_GEAR3:      gear_factor[2] = cfg_ch.data;
                    REG_FACTOR_GEAR4:      gear_factor[3] = cfg_ch.data;
                    REG_FACTOR_GEAR5:      gear_factor[4] = cfg_ch.data;
                    REG_UPSHIFT_RPM:       up_thr = cfg_ch.data;
                    REG_DOWNSHIFT_RPM:     down_thr = cfg_ch.data;
                    REG_TOP_DOWNSHIFT_RPM: top_thr = cfg_ch.data;
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready) begin
                samples_in++;
                outcome_q.push_back(predict_shift(sample_ch.speed_kmh));
            end
        end
    end

    always @(posedge clk) begin
        if (pattern_age == 0) begin
            stall_pattern = 8'($urandom_range(1, 255));
            pattern_age   = 97;
        end else begin
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            pattern_age--;
        end
        result_ch.ready <= receiver_stalls ? stall_pattern[0] : 1'b1;
    end

    always @(posedge clk) begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results pending",
                     quiet_cycles, outcome_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_speed(input speed_t spd);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_idles) gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid     <= 1'b1;
        sample_ch.speed_kmh <= spd;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outcome_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_idx_t idx, input cfg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic program_regs();
        put_reg(REG_FACTOR_GEAR1, set_factor[0]);
        put_reg(REG_FACTOR_GEAR2, set_factor[1]);
        put_reg(REG_FACTOR_GEAR3, set_factor[2]);
        put_reg(REG_FACTOR_GEAR4, set_factor[3]);
        put_reg(REG_FACTOR_GEAR5, set_factor[4]);
        put_reg(REG_UPSHIFT_RPM, set_up);
        put_reg(REG_DOWNSHIFT_RPM, set_down);
        put_reg(REG_TOP_DOWNSHIFT_RPM, set_top);
        cfg_ch.valid <= 1'b0;
        settings_cnt++;
    endtask

    function automatic void stage_defaults();
        set_factor[0] = FACTOR_GEAR1_RST;
        set_factor[1] = FACTOR_GEAR2_RST;
        set_factor[2] = FACTOR_GEAR3_RST;
        set_factor[3] = FACTOR_GEAR4_RST;
        set_factor[4] = FACTOR_GEAR5_RST;
        set_up   = UPSHIFT_RPM_RST;
        set_down = DOWNSHIFT_RPM_RST;
        set_top  = TOP_DOWNSHIFT_RPM_RST;
    endfunction

    function automatic cfg_data_t pick_extreme();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return FULL_SCALE;
            2:       return UNITY_FACTOR;
            default: return cfg_data_t'($urandom);
        endcase
    endfunction

    // mostly a drive-like random walk, with occasional jumps and extremes
    function automatic speed_t next_speed();
        int          delta;
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 17) begin
            delta = int'($urandom_range(0, 2 * walk_step)) - int'(walk_step);
            if (int'(walk_speed) + delta < 0)
                walk_speed = '0;
            else if (int'(walk_speed) + delta > int'(SPEED_TOP))
                walk_speed = SPEED_TOP;
            else
                walk_speed = speed_t'(int'(walk_speed) + delta);
        end else if (pick < 19) begin
            walk_speed = speed_t'($urandom);
        end else begin
            walk_speed = ($urandom_range(0, 1) != 0) ? SPEED_TOP : '0;
        end
        return walk_speed;
    endfunction

    // reset settings: climb to top gear on saturated rpm, drop back, bit patterns
    task automatic test_reset_config();
        send_speed('0);
        repeat (5) send_speed(SPEED_TOP);
        send_speed('0);
        send_speed(10'h155);
        send_speed(10'h2aa);
        drain();
    endtask

    // unity factors make rpm equal speed, so thresholds are hit exactly
    task automatic test_threshold_edges();
        for (int g = 0; g < GEARS; g++) set_factor[g] = UNITY_FACTOR;
        set_up   = 16'd500;
        set_down = 16'd200;
        set_top  = 16'd300;
        program_regs();
        send_speed(10'd301);
        send_speed(10'd300);
        send_speed(10'd201);
        send_speed(10'd200);
        send_speed(10'd200);
        send_speed(10'd200);
        send_speed(10'd0);
        send_speed(10'd499);
        send_speed(10'd500);
        drain();
        // upshift and downshift both hold: upshift wins
        set_up   = 16'd100;
        set_down = 16'd200;
        program_regs();
        send_speed(10'd150);
        drain();
    endtask

    task automatic test_extreme_settings();
        for (int g = 0; g < GEARS; g++) set_factor[g] = FULL_SCALE;
        set_up   = FULL_SCALE;
        set_down = '0;
        set_top  = '0;
        program_regs();
        send_speed(SPEED_TOP);
        send_speed(SPEED_TOP);
        send_speed(10'd1);
        send_speed('0);
        drain();
    endtask

    // every sample shifts: climb to fifth, then toggle between fourth and fifth
    task automatic test_gear_toggle();
        stage_defaults();
        set_up  = '0;
        set_top = FULL_SCALE;
        program_regs();
        sender_idles    = 1'b0;
        receiver_stalls = 1'b0;
        repeat (TOGGLE_ITEMS) send_speed(speed_t'($urandom));
        drain();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0, 5: stage_defaults();
                1: begin
                    for (int g = 0; g < GEARS; g++)
                        set_factor[g] = cfg_data_t'($urandom_range(2000, 30000));
                    set_up   = cfg_data_t'($urandom_range(1500, 6000));
                    set_down = cfg_data_t'($urandom_range(200, 1500));
                    set_top  = cfg_data_t'($urandom_range(800, 3000));
                end
                2: begin
                    for (int g = 0; g < GEARS; g++) set_factor[g] = cfg_data_t'($urandom);
                    set_up   = cfg_data_t'($urandom);
                    set_down = cfg_data_t'($urandom);
                    set_top  = cfg_data_t'($urandom);
                end
                default: begin
                    for (int g = 0; g < GEARS; g++) set_factor[g] = pick_extreme();
                    set_up   = pick_extreme();
                    set_down = pick_extreme();
                    set_top  = pick_extreme();
                end
            endcase
            program_regs();
            sender_idles    = (phase == 0) || (phase != 3 && $urandom_range(0, 3) != 0);
            receiver_stalls = (phase == 0) || (phase != 3 && $urandom_range(0, 3) != 0);
            walk_step       = $urandom_range(3, 40);
            repeat (ITEMS_PER_PHASE) send_speed(next_speed());
            drain();
        end
    endtask

    initial begin
        rst_n               <= 1'b0;
        sample_ch.valid     <= 1'b0;
        sample_ch.speed_kmh <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.index        <= REG_FACTOR_GEAR1;
        cfg_ch.data         <= '0;
        reset_model();
        walk_speed      = '0;
        walk_step       = 10;
        burst_left      = 0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_threshold_edges();
        test_extreme_settings();
        test_random_traffic();
        test_gear_toggle();

        if (outcome_q.size() != 0) begin
            fail_cnt++;
            $display("%0d expected results never arrived", outcome_q.size());
        end
        $display("Checked %0d speed samples and %0d results across %0d register settings",
                 samples_in, results_out, settings_cnt);
        $display("Predicted %0d upshifts and %0d downshifts; %0d failures",
                 upshifts, downshifts, fail_cnt);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/gsc_pkg.sv
design/gsc_if.sv
design/gear_shift_controller_unit.sv
dv/gear_shift_controller_unit_test.sv
